[src/whcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package whcp_pkg;

   localparam int MaxDim    = 1024;
   localparam int PixelBits = 16;
   localparam int DimBits   = $clog2(MaxDim) + 1;
   localparam int CoordBits = $clog2(MaxDim);
   localparam int MarginBits = 8;

   typedef enum logic [1:0] {
      CsrFrameWidth  = 2'd0,
      CsrFrameHeight = 2'd1,
      CsrMargin      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        first_of_frame;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] hot_value;
      logic [9:0]  hot_col;
      logic [9:0]  hot_row;
      logic [15:0] cold_value;
      logic [9:0]  cold_col;
      logic [9:0]  cold_row;
   } rsp_type;

   // per-pixel control from the counter stage to the trackers
   typedef struct packed {
      logic update;
      logic restart;
      logic in_window;
      logic last;
   } track_ctrl_type;

   // zero reads as one, anything above the largest frame as the largest frame
   function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v);
      logic [DimBits-1:0] r;
      r = v;
      if (v == '0) begin
         r = DimBits'(1);
      end else if (v > DimBits'(MaxDim)) begin
         r = DimBits'(MaxDim);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/whcp_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
module whcp_tracker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire whcp_pkg::track_ctrl_type          ctrl,
   input  wire logic [whcp_pkg::PixelBits-1:0]    pixel,
   input  wire logic [whcp_pkg::CoordBits-1:0]    col,
   input  wire logic [whcp_pkg::CoordBits-1:0]    row,
   output whcp_pkg::rsp_type                      result
);

   logic                              seen_ff, seen_in;
   logic [whcp_pkg::PixelBits-1:0]    max_value_ff, max_value_in;
   logic [whcp_pkg::CoordBits-1:0]    max_col_ff, max_col_in;
   logic [whcp_pkg::CoordBits-1:0]    max_row_ff, max_row_in;
   logic [whcp_pkg::PixelBits-1:0]    min_value_ff, min_value_in;
   logic [whcp_pkg::CoordBits-1:0]    min_col_ff, min_col_in;
   logic [whcp_pkg::CoordBits-1:0]    min_row_ff, min_row_in;

   logic                              eff_seen;
   logic                              hot_take;
   logic                              cold_take;
   logic                              nxt_seen;
   logic [whcp_pkg::PixelBits-1:0]    nxt_max_value;
   logic [whcp_pkg::CoordBits-1:0]    nxt_max_col;
   logic [whcp_pkg::CoordBits-1:0]    nxt_max_row;
   logic [whcp_pkg::PixelBits-1:0]    nxt_min_value;
   logic [whcp_pkg::CoordBits-1:0]    nxt_min_col;
   logic [whcp_pkg::CoordBits-1:0]    nxt_min_row;

   // a restart discards the old trackers; first window pixel seeds both
   always_comb begin
      eff_seen  = seen_ff && !ctrl.restart;
      hot_take  = ctrl.in_window && (!eff_seen || (pixel > max_value_ff));
      cold_take = ctrl.in_window && (!eff_seen || (pixel < min_value_ff));
      nxt_seen  = eff_seen || ctrl.in_window;

      nxt_max_value = hot_take  ? pixel : max_value_ff;
      nxt_max_col   = hot_take  ? col   : max_col_ff;
      nxt_max_row   = hot_take  ? row   : max_row_ff;
      nxt_min_value = cold_take ? pixel : min_value_ff;
      nxt_min_col   = cold_take ? col   : min_col_ff;
      nxt_min_row   = cold_take ? row   : min_row_ff;
   end

   always_comb begin
      result = '0;
      if (nxt_seen) begin
         result.found      = 1'b1;
         result.hot_value  = 16'(nxt_max_value);
         result.hot_col    = 10'(nxt_max_col);
         result.hot_row    = 10'(nxt_max_row);
         result.cold_value = 16'(nxt_min_value);
         result.cold_col   = 10'(nxt_min_col);
         result.cold_row   = 10'(nxt_min_row);
      end
   end

   always_comb begin
      seen_in      = seen_ff;
      max_value_in = max_value_ff;
      max_col_in   = max_col_ff;
      max_row_in   = max_row_ff;
      min_value_in = min_value_ff;
      min_col_in   = min_col_ff;
      min_row_in   = min_row_ff;
      if (ctrl.update) begin
         if (ctrl.last) begin
            seen_in      = 1'b0;
            max_value_in = '0;
            max_col_in   = '0;
            max_row_in   = '0;
            min_value_in = '1;
            min_col_in   = '0;
            min_row_in   = '0;
         end else begin
            seen_in      = nxt_seen;
            max_value_in = nxt_max_value;
            max_col_in   = nxt_max_col;
            max_row_in   = nxt_max_row;
            min_value_in = nxt_min_value;
            min_col_in   = nxt_min_col;
            min_row_in   = nxt_min_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         max_value_ff <= '0;
         max_col_ff   <= '0;
         max_row_ff   <= '0;
         min_value_ff <= '1;
         min_col_ff   <= '0;
         min_row_ff   <= '0;
      end else begin
         seen_ff      <= seen_in;
         max_value_ff <= max_value_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         min_value_ff <= min_value_in;
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
      end
   end

endmodule
`default_nettype wire

[src/window_hot_cold_pixel_finder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// a frame's last pixel is held in the input register, then its result is loaded into the result register
// and is transferred from there when rsp_ready is high
// throughput: one pixel per cycle, set by the single input register and result register
// the input only stalls when a frame's last pixel meets a result still waiting for rsp_ready
// reset (synchronous, active high) clears counters, trackers and valids and
// restores frame_width 256, frame_height 192, margin 20; no clearing pass
module window_hot_cold_pixel_finder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire whcp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output whcp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [10:0]       csr_data
);

   // configuration registers
   logic [whcp_pkg::DimBits-1:0]    frame_width_ff, frame_width_in;
   logic [whcp_pkg::DimBits-1:0]    frame_height_ff, frame_height_in;
   logic [whcp_pkg::MarginBits-1:0] margin_ff, margin_in;

   // input register
   logic                            s1_valid_ff, s1_valid_in;
   whcp_pkg::req_type               s1_data_ff, s1_data_in;

   // raster position
   logic [whcp_pkg::CoordBits-1:0]  col_ff, col_in;
   logic [whcp_pkg::CoordBits-1:0]  row_ff, row_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   whcp_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [whcp_pkg::DimBits-1:0]    width_eff;
   logic [whcp_pkg::DimBits-1:0]    height_eff;
   logic [whcp_pkg::CoordBits-1:0]  cur_col;
   logic [whcp_pkg::CoordBits-1:0]  cur_row;
   logic [whcp_pkg::DimBits-1:0]    margin_ext;
   logic                            in_window;
   logic                            row_end;
   logic                            last;
   logic                            advance;
   whcp_pkg::track_ctrl_type        track_ctrl;
   whcp_pkg::rsp_type               frame_result;

   assign csr_ready = 1'b1;

   // configuration writes; an index beyond the list is dropped
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      margin_in       = margin_ff;
      if (csr_valid && csr_ready) begin
         case (whcp_pkg::csr_index_type'(csr_index))
            whcp_pkg::CsrFrameWidth:  frame_width_in  = csr_data;
            whcp_pkg::CsrFrameHeight: frame_height_in = csr_data;
            whcp_pkg::CsrMargin:      margin_in       = csr_data[whcp_pkg::MarginBits-1:0];
            default:                  ;
         endcase
      end
   end

   // frame geometry for the pixel held in the input register
   always_comb begin
      width_eff  = whcp_pkg::clamp_dim(frame_width_ff);
      height_eff = whcp_pkg::clamp_dim(frame_height_ff);
      margin_ext = whcp_pkg::DimBits'(margin_ff);
      // first_of_frame forces the pixel to column 0, row 0
      cur_col = s1_data_ff.first_of_frame ? '0 : col_ff;
      cur_row = s1_data_ff.first_of_frame ? '0 : row_ff;
      // window test, sums kept one bit wider so nothing wraps
      in_window = ({1'b0, cur_col} >= margin_ext)
               && (({1'b0, cur_col} + margin_ext) < width_eff)
               && ({1'b0, cur_row} >= margin_ext)
               && (({1'b0, cur_row} + margin_ext) < height_eff);
      // >= so that a shrunk frame size still closes the row or frame
      row_end = ({1'b0, cur_col} + whcp_pkg::DimBits'(1)) >= width_eff;
      last    = row_end && (({1'b0, cur_row} + whcp_pkg::DimBits'(1)) >= height_eff);
   end

   // a held pixel moves on unless it closes a frame while a result is still waiting
   assign advance   = s1_valid_ff && (!last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // raster counters step on each pixel that moves on
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = cur_row + whcp_pkg::CoordBits'(1);
         end else begin
            col_in = cur_col + whcp_pkg::CoordBits'(1);
            row_in = cur_row;
         end
      end
   end

   always_comb begin
      track_ctrl.update    = advance;
      track_ctrl.restart   = s1_data_ff.first_of_frame;
      track_ctrl.in_window = in_window;
      track_ctrl.last      = last;
   end

   whcp_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (track_ctrl),
      .pixel  (s1_data_ff.pixel[whcp_pkg::PixelBits-1:0]),
      .col    (cur_col),
      .row    (cur_row),
      .result (frame_result)
   );

   // result register: loaded at the frame's last pixel, emptied on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = frame_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= whcp_pkg::DimBits'(256);
         frame_height_ff <= whcp_pkg::DimBits'(192);
         margin_ff       <= whcp_pkg::MarginBits'(20);
         s1_valid_ff     <= 1'b0;
         col_ff          <= '0;
         row_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         margin_ff       <= margin_in;
         s1_valid_ff     <= s1_valid_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // an empty window reports all-zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
         (rsp_data_ff.hot_value == '0 && rsp_data_ff.cold_value == '0
          && rsp_data_ff.hot_col == '0 && rsp_data_ff.cold_row == '0))
      else $error("empty window result carries data");

   // the coldest value never exceeds the hottest
   a_cold_le_hot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found) |->
         (rsp_data_ff.cold_value <= rsp_data_ff.hot_value))
      else $error("cold value above hot value");

   // closing a frame returns the raster counters to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (advance && last) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters not cleared at frame end");

   // the input side only stalls on a held pixel that cannot move on
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && last && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without cause");
`endif

endmodule
`default_nettype wire

[bench/window_hot_cold_pixel_finder_unit_tb.sv]
`timescale 1ns / 1ps
module window_hot_cold_pixel_finder_unit_tb;

   localparam int ClockHalf    = 6;    // 12 ns period
   localparam int ResetCycles  = 11;
   localparam int SettleCycles = 4;    // pixel-to-result latency plus slack
   localparam int RandomItems  = 700;
   localparam int SteadyItems  = 150;
   // index that maps to no register, writes to it must change nothing
   localparam logic [1:0] CsrUnused = 2'd3;

   typedef enum int {
      StyleRandom,
      StyleTies,
      StyleExtremes,
      StyleRising,
      StyleFalling
   } pixel_style_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   whcp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   whcp_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [10:0]       csr_data;

   // no idling on either side once set
   bit calm = 1'b0;
   int mismatches = 0;
   int pixels_sent = 0;

   // predictor copy of the registers and the frame state
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   logic [7:0]  margin_reg;
   int          col_pos;
   int          row_pos;
   // running extremes, found doubles as the seeded flag
   whcp_pkg::rsp_type best;
   whcp_pkg::rsp_type frame_results_q[$];

   window_hot_cold_pixel_finder_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockHalf) clock = ~clock;
   end

   // zero counts as one, anything past the largest frame as the largest frame
   function automatic int fit_dim(input logic [10:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > whcp_pkg::MaxDim) begin
         return whcp_pkg::MaxDim;
      end
      return int'(v);
   endfunction

   task automatic reset_extremes();
      best = '0;
      best.cold_value = '1;
   endtask

   // advance the predictor by one accepted pixel
   task automatic track_pixel(input whcp_pkg::req_type item);
      int   w;
      int   h;
      int   m;
      logic in_window;
      logic row_end;
      logic frame_end;
      w = fit_dim(width_reg);
      h = fit_dim(height_reg);
      m = int'(margin_reg);
      if (item.first_of_frame) begin
         col_pos = 0;
         row_pos = 0;
         reset_extremes();
      end
      // margin checks written so that nothing underflows
      in_window = col_pos >= m && col_pos + m < w && row_pos >= m && row_pos + m < h;
      if (in_window) begin
         if (!best.found) begin
            // first in-window pixel seeds both ends
            best.found      = 1'b1;
            best.hot_value  = item.pixel;
            best.hot_col    = col_pos[9:0];
            best.hot_row    = row_pos[9:0];
            best.cold_value = item.pixel;
            best.cold_col   = col_pos[9:0];
            best.cold_row   = row_pos[9:0];
         end else begin
            // strict compares keep the first occurrence in raster order
            if (item.pixel < best.cold_value) begin
               best.cold_value = item.pixel;
               best.cold_col   = col_pos[9:0];
               best.cold_row   = row_pos[9:0];
            end
            if (item.pixel > best.hot_value) begin
               best.hot_value = item.pixel;
               best.hot_col   = col_pos[9:0];
               best.hot_row   = row_pos[9:0];
            end
         end
      end
      // a counter at or past the edge (registers shrunk mid-frame) still ends the line
      row_end   = col_pos + 1 >= w;
      frame_end = row_end && row_pos + 1 >= h;
      if (frame_end) begin
         // an empty window reports all zeros
         if (best.found) begin
            frame_results_q.push_back(best);
         end else begin
            frame_results_q.push_back(whcp_pkg::rsp_type'('0));
         end
         col_pos = 0;
         row_pos = 0;
         reset_extremes();
      end else if (row_end) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // samples every transfer at the rising edge; predictor first, then result check
   always @(posedge clock) begin : frame_monitor
      whcp_pkg::rsp_type want;
      if (reset) begin
         width_reg  = 11'd256;
         height_reg = 11'd192;
         margin_reg = 8'd20;
         col_pos    = 0;
         row_pos    = 0;
         reset_extremes();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               whcp_pkg::CsrFrameWidth:  width_reg  = csr_data;
               whcp_pkg::CsrFrameHeight: height_reg = csr_data;
               whcp_pkg::CsrMargin:      margin_reg = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            track_pixel(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_results_q.size() == 0) begin
               $display("%0t ns: result transfer with none expected, actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = frame_results_q.pop_front();
               check_field("found",      16'(want.found),      16'(rsp_data.found));
               check_field("hot_value",  want.hot_value,       rsp_data.hot_value);
               check_field("hot_col",    16'(want.hot_col),    16'(rsp_data.hot_col));
               check_field("hot_row",    16'(want.hot_row),    16'(rsp_data.hot_row));
               check_field("cold_value", want.cold_value,      rsp_data.cold_value);
               check_field("cold_col",   16'(want.cold_col),   16'(rsp_data.cold_col));
               check_field("cold_row",   16'(want.cold_row),   16'(rsp_data.cold_row));
            end
         end
      end
   end

   // result side back-pressure in random bursts
   initial begin : rsp_ready_driver
      int len;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (len - 1) @(negedge clock);
         end else begin
            len = $urandom_range(1, 20);
            rsp_ready <= 1'b1;
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   // one pixel transfer; valid is left high so back-to-back items need no gap
   task automatic send_pixel(input logic [15:0] pix, input logic first);
      whcp_pkg::req_type item;
      int                gap;
      item.pixel = pix;
      item.first_of_frame = first;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // stop sending and let every outstanding result drain, pixels in flight included
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_results_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [10:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_pixel(input pixel_style_type style, input int i);
      case (style)
         StyleTies:     return 16'($urandom_range(0, 3));
         StyleExtremes: begin
            case ($urandom_range(0, 2))
               0:       return 16'h0000;
               1:       return 16'hFFFF;
               default: return 16'($urandom);
            endcase
         end
         StyleRising:   return i[15:0];
         StyleFalling:  return ~i[15:0];
         default:       return 16'($urandom);
      endcase
   endfunction

   // one frame in raster order; when noisy, frames may be cut short, restarted
   // part way through, or start without the first-of-frame flag
   task automatic send_frame(input int count, input pixel_style_type style, input bit noisy);
      int n;
      bit first;
      n = count;
      if (noisy && $urandom_range(0, 29) == 0) begin
         n = $urandom_range(1, count);
      end
      for (int i = 0; i < n; i++) begin
         first = (i == 0);
         if (noisy) begin
            if (i == 0 && $urandom_range(0, 9) == 0) begin
               first = 1'b0;
            end else if (i != 0 && $urandom_range(0, 99) == 0) begin
               first = 1'b1;
            end
         end
         send_pixel(pick_pixel(style, i), first);
      end
   endtask

   // width 256 and margin 20 left at their reset values; a single row keeps
   // the whole frame outside the window
   task automatic test_reset_defaults();
      write_csr(whcp_pkg::CsrFrameHeight, 11'd1);
      send_frame(256, StyleRandom, 1'b0);
   endtask

   task automatic test_directed_cases();
      // single in-window pixel seeds both ends
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameWidth, 11'd3);
      write_csr(whcp_pkg::CsrFrameHeight, 11'd3);
      write_csr(whcp_pkg::CsrMargin, 11'd1);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h1234, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);

      // ties on both ends, the first in raster order must win
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameHeight, 11'd2);
      write_csr(whcp_pkg::CsrMargin, 11'd0);
      send_pixel(16'd5, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'd5, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b0);

      // margin wider than the frame, upper data bits must be dropped
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameWidth, 11'd2);
      write_csr(whcp_pkg::CsrFrameHeight, 11'd1);
      write_csr(whcp_pkg::CsrMargin, 11'h7FF);
      send_pixel(16'h8001, 1'b1);
      send_pixel(16'h7FFE, 1'b0);

      // zero sizes read as one, frames end without the first-of-frame flag
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameWidth, 11'd0);
      write_csr(whcp_pkg::CsrFrameHeight, 11'd0);
      write_csr(whcp_pkg::CsrMargin, 11'd0);
      send_pixel(16'hABCD, 1'b1);
      send_pixel(16'h5432, 1'b0);

      // restart part way through a frame
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameWidth, 11'd3);
      write_csr(whcp_pkg::CsrFrameHeight, 11'd1);
      send_pixel(16'd9, 1'b1);
      send_pixel(16'd1, 1'b0);
      send_pixel(16'd7, 1'b1);
      send_pixel(16'd3, 1'b0);
      send_pixel(16'd8, 1'b0);

      // width then height shrunk mid-frame so the counters sit past the edge
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameWidth, 11'd4);
      write_csr(whcp_pkg::CsrFrameHeight, 11'd2);
      send_pixel(16'd10, 1'b1);
      send_pixel(16'd20, 1'b0);
      send_pixel(16'd30, 1'b0);
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameWidth, 11'd2);
      send_pixel(16'd40, 1'b0);
      send_pixel(16'd50, 1'b0);
      wait_for_results();
      write_csr(whcp_pkg::CsrFrameHeight, 11'd1);
      send_pixel(16'd60, 1'b0);

      // a write to the unused index must leave all registers alone
      wait_for_results();
      write_csr(CsrUnused, 11'h5A5);
      send_pixel(16'h00FF, 1'b1);
      send_pixel(16'hFF00, 1'b0);
   endtask

   // small frames with random content; every phase starts from an empty pipeline
   task automatic test_random_frames();
      int          start;
      int          frames;
      logic [10:0] wv;
      logic [10:0] hv;
      start = pixels_sent;
      while (pixels_sent - start < RandomItems) begin
         wait_for_results();
         wv = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
         hv = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
         write_csr(whcp_pkg::CsrFrameWidth, wv);
         write_csr(whcp_pkg::CsrFrameHeight, hv);
         if ($urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 9) == 0) begin
               write_csr(whcp_pkg::CsrMargin, 11'($urandom_range(0, 2047)));
            end else begin
               write_csr(whcp_pkg::CsrMargin, 11'($urandom_range(0, 4)));
            end
         end
         frames = $urandom_range(1, 4);
         repeat (frames) begin
            send_frame(fit_dim(wv) * fit_dim(hv),
                       pixel_style_type'($urandom_range(0, 4)), 1'b1);
         end
      end
   endtask

   // closing stretch at full rate, no idling on either side
   task automatic test_steady_stream();
      int          start;
      logic [10:0] wv;
      logic [10:0] hv;
      wait_for_results();
      calm  = 1'b1;
      start = pixels_sent;
      while (pixels_sent - start < SteadyItems) begin
         wait_for_results();
         wv = 11'($urandom_range(1, 6));
         hv = 11'($urandom_range(1, 6));
         write_csr(whcp_pkg::CsrFrameWidth, wv);
         write_csr(whcp_pkg::CsrFrameHeight, hv);
         write_csr(whcp_pkg::CsrMargin, 11'($urandom_range(0, 2)));
         repeat (3) begin
            send_frame(int'(wv) * int'(hv), pixel_style_type'($urandom_range(0, 4)), 1'b0);
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_random_frames();
      test_steady_stream();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #(8_000_000);
      $display("%0t ns: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
